@@ design/eoel_pkg.sv @@
// Package for the error-ordered eviction list unit.
// Holds operation codes, status codes and fixed field widths.
// No dependencies.
package eoel_pkg;

	localparam int unsigned MODE_W   = 3;
	localparam int unsigned ERRIN_W  = 16;
	localparam int unsigned RND_W    = 32;
	localparam int unsigned FRAC_W   = 16;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned FRAC_RESET = 19661;

	typedef logic [MODE_W-1:0]   mode_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam mode_t MODE_APPEND = 3'd0;
	localparam mode_t MODE_UNLINK = 3'd1;
	localparam mode_t MODE_RAISE  = 3'd2;
	localparam mode_t MODE_LOWER  = 3'd3;
	localparam mode_t MODE_REAP   = 3'd4;

	localparam status_t STATUS_DONE    = 2'd0;
	localparam status_t STATUS_FLOOR   = 2'd1;
	localparam status_t STATUS_NO_ALT  = 2'd2;

endpackage

@@ design/eoel_if.sv @@
// Channel interfaces of the error-ordered eviction list unit.
// Depends on eoel_pkg for the fixed field widths.
interface eoel_req_if #(parameter int IW = 10);
	logic                           valid;
	logic                           ready;
	logic [eoel_pkg::MODE_W-1:0]    mode;
	logic [IW-1:0]                  cell_index;
	logic [eoel_pkg::ERRIN_W-1:0]   error_count;
	logic [eoel_pkg::RND_W-1:0]     random_word;
	logic                           exclude_enable;
	logic [IW-1:0]                  excluded_index;
	modport source (output valid, mode, cell_index, error_count, random_word,
		exclude_enable, excluded_index, input ready);
	modport sink (input valid, mode, cell_index, error_count, random_word,
		exclude_enable, excluded_index, output ready);
endinterface

interface eoel_rsp_if #(parameter int IW = 10, parameter int LW = 11);
	logic                            valid;
	logic                            ready;
	logic [eoel_pkg::STATUS_W-1:0]   status;
	logic [IW-1:0]                   victim_index;
	logic [LW-1:0]                   population;
	logic [LW-1:0]                   top_index;
	modport source (output valid, status, victim_index, population, top_index,
		input ready);
	modport sink (input valid, status, victim_index, population, top_index,
		output ready);
endinterface

interface eoel_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [eoel_pkg::FRAC_W-1:0]   data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ design/error_ordered_eviction_list_unit.sv @@
// Error-ordered eviction list: sequencer over link, error and member memories.
// Depends on eoel_pkg and the channel interfaces in eoel_if.sv.
// Each item runs to completion: a reap is refused at the floor, else it divides
//   the random word by the range (reap_fraction times population) for the
//   remainder, walks that many steps over the next-link memory port and lets a
//   neighbor replace the excluded entry; below a range of two it does not divide.
//   A result not yet taken holds the next one. One item at a time, no overlap.
// Reset: list empty, reap_fraction 19661; a clearing pass over every entry of
//   the member memory follows, during which no item is accepted.
module error_ordered_eviction_list_unit #(
	parameter int ENTRIES   = 1024,
	parameter int ERR_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	eoel_cfg_if.sink    cfg,
	eoel_req_if.sink    req,
	eoel_rsp_if.source  rsp
);
	import eoel_pkg::*;

	localparam int IW  = $clog2(ENTRIES);
	localparam int LW  = $clog2(ENTRIES + 1);
	localparam int EXT = (ERR_WIDTH > ERRIN_W) ? ERR_WIDTH : ERRIN_W;
	localparam logic [LW-1:0] NONE = LW'(ENTRIES);
	localparam int DCW = $clog2(RND_W);

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_RD, S_DEC, S_NB, S_CMP, S_L1, S_L2, S_L3,
		S_APP, S_APP2, S_UNL, S_RCHK, S_RNG, S_DIV, S_WALK, S_WSTEP,
		S_EXC, S_ALT, S_RUL, S_RUL2, S_DONE
	} state_t;

	// memories
	logic [LW-1:0]        next_mem [ENTRIES];
	logic [LW-1:0]        prev_mem [ENTRIES];
	logic [ERR_WIDTH-1:0] err_mem  [ENTRIES];
	logic                 memb_mem [ENTRIES];

	logic                 next_we, prev_we, err_we, memb_we;
	logic [IW-1:0]        next_wa, prev_wa, err_wa, memb_wa;
	logic [LW-1:0]        next_wd, prev_wd;
	logic                 memb_wd;
	logic [IW-1:0]        next_ra, prev_ra, err_ra, memb_ra;
	logic [LW-1:0]        n_rd, p_rd;
	logic [ERR_WIDTH-1:0] e_rd;
	logic                 m_rd;

	state_t               state_q;
	logic [MODE_W-1:0]    mode_q;
	logic [IW-1:0]        idx_q, exidx_q, clr_q, victim_q;
	logic [ERR_WIDTH-1:0] err_q;
	logic [RND_W-1:0]     rnd_q;
	logic                 ex_q;
	logic [LW-1:0]        head_q, tail_q, count_q;
	logic [LW-1:0]        n_q, p_q, x_q, cur_q, steps_q, i_q, rem_q;
	logic [LW-1:0]        le_q, lu_q, luu_q, ld_q;
	logic [FRAC_W+LW-1:0] prod_q;
	logic [DCW-1:0]       dcnt_q;
	logic [FRAC_W-1:0]    frac_q;
	status_t              status_q;
	logic                 out_valid_q;
	status_t              o_status_q;
	logic [IW-1:0]        o_victim_q;
	logic [LW-1:0]        o_pop_q, o_top_q;

	logic [EXT-1:0]       err_wide;
	logic [LW-1:0]        range_w;
	logic [LW:0]          dtrial;
	logic [LW-1:0]        drem;
	logic                 lift_ok;

	always_ff @(posedge clk) begin
		if (next_we) next_mem[next_wa] <= next_wd;
		if (prev_we) prev_mem[prev_wa] <= prev_wd;
		if (err_we)  err_mem[err_wa]   <= err_q;
		if (memb_we) memb_mem[memb_wa] <= memb_wd;
		n_rd <= next_mem[next_ra];
		p_rd <= prev_mem[prev_ra];
		e_rd <= err_mem[err_ra];
		m_rd <= memb_mem[memb_ra];
	end

	assign err_wide = EXT'(req.error_count);
	assign range_w  = prod_q[FRAC_W +: LW];
	assign dtrial   = {rem_q, rnd_q[RND_W-1]};
	assign drem     = (dtrial >= {1'b0, range_w}) ? LW'(dtrial - {1'b0, range_w})
		: dtrial[LW-1:0];
	assign lift_ok  = (mode_q == MODE_RAISE) ? (err_q >= e_rd) : (err_q <= e_rd);

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid        = out_valid_q;
	assign rsp.status       = o_status_q;
	assign rsp.victim_index = o_victim_q;
	assign rsp.population   = o_pop_q;
	assign rsp.top_index    = o_top_q;

	// memory control
	always_comb begin
		next_we = 1'b0; prev_we = 1'b0; err_we = 1'b0; memb_we = 1'b0;
		next_wa = idx_q; prev_wa = idx_q; err_wa = idx_q; memb_wa = idx_q;
		next_wd = NONE; prev_wd = NONE; memb_wd = 1'b0;
		next_ra = idx_q; prev_ra = idx_q; err_ra = x_q[IW-1:0]; memb_ra = idx_q;
		unique case (state_q)
			S_CLR: begin
				memb_we = 1'b1; memb_wa = clr_q;
			end
			S_RD: begin
				err_we = (mode_q != MODE_UNLINK);
			end
			S_NB: begin
				next_ra = x_q[IW-1:0]; prev_ra = x_q[IW-1:0];
			end
			S_L1: begin
				prev_we = 1'b1; prev_wa = le_q[IW-1:0]; prev_wd = luu_q;
				next_we = 1'b1; next_wa = le_q[IW-1:0]; next_wd = lu_q;
			end
			S_L2: begin
				prev_we = 1'b1; prev_wa = lu_q[IW-1:0]; prev_wd = le_q;
				next_we = 1'b1; next_wa = lu_q[IW-1:0]; next_wd = ld_q;
			end
			S_L3: begin
				next_we = (luu_q < NONE); next_wa = luu_q[IW-1:0]; next_wd = le_q;
				prev_we = (ld_q < NONE);  prev_wa = ld_q[IW-1:0];  prev_wd = lu_q;
			end
			S_APP: begin
				prev_we = 1'b1; prev_wd = tail_q;
				next_we = 1'b1; next_wd = NONE;
				memb_we = 1'b1; memb_wd = 1'b1;
			end
			S_APP2: begin
				next_we = 1'b1; next_wa = tail_q[IW-1:0]; next_wd = LW'(idx_q);
			end
			S_UNL: begin
				next_we = (p_q < NONE); next_wa = p_q[IW-1:0]; next_wd = n_q;
				prev_we = (n_q < NONE); prev_wa = n_q[IW-1:0]; prev_wd = p_q;
				memb_we = 1'b1; memb_wd = 1'b0;
			end
			S_WALK, S_EXC, S_RUL: begin
				next_ra = cur_q[IW-1:0]; prev_ra = cur_q[IW-1:0];
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			head_q      <= NONE;
			tail_q      <= NONE;
			count_q     <= '0;
			frac_q      <= FRAC_W'(FRAC_RESET);
			out_valid_q <= 1'b0;
			mode_q <= '0; idx_q <= '0; exidx_q <= '0; err_q <= '0; rnd_q <= '0;
			ex_q <= 1'b0; victim_q <= '0; status_q <= STATUS_DONE;
			n_q <= '0; p_q <= '0; x_q <= '0; cur_q <= '0; steps_q <= '0;
			i_q <= '0; rem_q <= '0; le_q <= '0; lu_q <= '0; luu_q <= '0;
			ld_q <= '0; prod_q <= '0; dcnt_q <= '0;
			o_status_q <= STATUS_DONE; o_victim_q <= '0; o_pop_q <= '0;
			o_top_q <= NONE;
		end else begin
			if (cfg.valid) frac_q <= cfg.data;
			if (out_valid_q && rsp.ready && state_q != S_DONE) out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IW'(ENTRIES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req.valid) begin
						mode_q   <= req.mode;
						idx_q    <= req.cell_index;
						err_q    <= err_wide[ERR_WIDTH-1:0];
						rnd_q    <= req.random_word;
						ex_q     <= req.exclude_enable;
						exidx_q  <= req.excluded_index;
						victim_q <= '0;
						status_q <= STATUS_DONE;
						if (req.mode == MODE_REAP)
							state_q <= S_RCHK;
						else if (req.mode < MODE_REAP && LW'(req.cell_index) < NONE)
							state_q <= S_RD;
						else
							state_q <= S_DONE;
					end
				end
				S_RD: state_q <= S_DEC;
				S_DEC: begin
					n_q <= n_rd;
					p_q <= p_rd;
					case (mode_q)
						MODE_APPEND: state_q <= m_rd ? S_DONE : S_APP;
						MODE_UNLINK: state_q <= m_rd ? S_UNL : S_DONE;
						MODE_RAISE: begin
							if (m_rd && p_rd < NONE) begin
								x_q <= p_rd; state_q <= S_NB;
							end else begin
								state_q <= S_DONE;
							end
						end
						MODE_LOWER: begin
							if (m_rd && n_rd < NONE) begin
								x_q <= n_rd; state_q <= S_NB;
							end else begin
								state_q <= S_DONE;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_NB: state_q <= S_CMP;
				S_CMP: begin
					if (mode_q == MODE_RAISE) begin
						le_q <= LW'(idx_q); lu_q <= p_q; luu_q <= p_rd; ld_q <= n_q;
					end else begin
						le_q <= n_q; lu_q <= LW'(idx_q); luu_q <= p_q; ld_q <= n_rd;
					end
					state_q <= lift_ok ? S_L1 : S_DONE;
				end
				S_L1: state_q <= S_L2;
				S_L2: state_q <= S_L3;
				S_L3: begin
					if (luu_q >= NONE) head_q <= le_q;
					if (ld_q >= NONE) tail_q <= lu_q;
					state_q <= S_DONE;
				end
				S_APP: begin
					count_q <= count_q + 1'b1;
					if (tail_q < NONE) begin
						state_q <= S_APP2;
					end else begin
						head_q  <= LW'(idx_q);
						tail_q  <= LW'(idx_q);
						state_q <= S_DONE;
					end
				end
				S_APP2: begin
					tail_q  <= LW'(idx_q);
					state_q <= S_DONE;
				end
				S_UNL: begin
					if (p_q >= NONE) head_q <= n_q;
					if (n_q >= NONE) tail_q <= p_q;
					count_q <= count_q - 1'b1;
					state_q <= S_DONE;
				end
				S_RCHK: begin
					if (count_q <= LW'(1) || head_q >= NONE) begin
						status_q <= STATUS_FLOOR;
						state_q  <= S_DONE;
					end else begin
						prod_q  <= (FRAC_W+LW)'(frac_q) * (FRAC_W+LW)'(count_q);
						cur_q   <= head_q;
						state_q <= S_RNG;
					end
				end
				S_RNG: begin
					rem_q  <= '0;
					dcnt_q <= '0;
					i_q    <= '0;
					if (range_w >= LW'(2)) begin
						state_q <= S_DIV;
					end else begin
						steps_q <= '0;
						state_q <= S_WALK;
					end
				end
				S_DIV: begin
					// one restoring remainder step per cycle, MSB first
					rem_q  <= drem;
					rnd_q  <= rnd_q << 1;
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DCW'(RND_W - 1)) begin
						steps_q <= drem;
						state_q <= S_WALK;
					end
				end
				S_WALK: state_q <= (i_q < steps_q) ? S_WSTEP : S_EXC;
				S_WSTEP: begin
					if (n_rd >= NONE) begin
						state_q <= S_EXC;
					end else begin
						cur_q   <= n_rd;
						i_q     <= i_q + 1'b1;
						state_q <= S_WALK;
					end
				end
				S_EXC: state_q <= (ex_q && cur_q == LW'(exidx_q)) ? S_ALT : S_RUL;
				S_ALT: begin
					// take the neighbor below at the top, else the one above
					if (cur_q == head_q) begin
						if (n_rd >= NONE) begin
							status_q <= STATUS_NO_ALT; state_q <= S_DONE;
						end else begin
							cur_q <= n_rd; state_q <= S_RUL;
						end
					end else begin
						if (p_rd >= NONE) begin
							status_q <= STATUS_NO_ALT; state_q <= S_DONE;
						end else begin
							cur_q <= p_rd; state_q <= S_RUL;
						end
					end
				end
				S_RUL: state_q <= S_RUL2;
				S_RUL2: begin
					n_q      <= n_rd;
					p_q      <= p_rd;
					idx_q    <= cur_q[IW-1:0];
					victim_q <= cur_q[IW-1:0];
					state_q  <= S_UNL;
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						o_status_q  <= status_q;
						o_victim_q  <= victim_q;
						o_pop_q     <= count_q;
						o_top_q     <= head_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
